// ===== design/hph_pkg.sv =====
package hph_pkg;

   localparam int BIN_SLOTS   = 1024;
   localparam int PARTITIONS  = 2048;
   localparam int COUNT_WIDTH = 32;
   localparam int BIN_W       = $clog2(BIN_SLOTS);
   localparam int PART_W      = $clog2(PARTITIONS);
   localparam int MAX_PART_BITS = 11;

   localparam logic [1:0] MODE_COUNT    = 2'd0;
   localparam logic [1:0] MODE_READ_BIN = 2'd1;
   localparam logic [1:0] MODE_READ_PRT = 2'd2;
   localparam logic [1:0] MODE_NONE     = 2'd3;

   localparam logic [1:0] REG_PART_BITS = 2'd0;
   localparam logic [1:0] REG_BIN_COUNT = 2'd1;
   localparam logic [1:0] REG_MAX_KEY   = 2'd2;

   localparam logic [31:0] MIX_C1 = 32'h85ebca6b;
   localparam logic [31:0] MIX_C2 = 32'hc2b2ae35;

   // controller to datapath
   typedef struct packed {
      logic load;     // capture input beat
      logic mix1;     // h ^= h>>16, h *= c1
      logic mix2;     // h ^= h>>13, h *= c2
      logic mix3;     // final xor, form partition
      logic mul;      // key * num of bins
      logic div_init;
      logic div_step;
      logic rd;       // issue memory reads
      logic wr;       // write back counters
      logic clr;      // clearing sweep write
      logic out_load; // capture result
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic clr_done;
      logic is_count;
   } sts_type;

endpackage

// ===== design/hph_ctrl.sv =====
module hph_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  hph_pkg::sts_type sts,
   output hph_pkg::cmd_type cmd
);
   import hph_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_MIX1  = 4'd2;
   localparam logic [3:0] S_MIX2  = 4'd3;
   localparam logic [3:0] S_MIX3  = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_RD    = 4'd6;
   localparam logic [3:0] S_RDW   = 4'd7;
   localparam logic [3:0] S_WR    = 4'd8;
   localparam logic [3:0] S_OUT   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic       vld_ff, vld_in;

   assign rsp_tvalid = vld_ff;
   // output register parts the sides: accept while result waits if it leaves now
   assign req_tready = (state_ff == S_IDLE) && (!vld_ff || rsp_tready);

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      vld_in = vld_ff;
      if (rsp_tready) vld_in = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (sts.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load = 1'b1;
               state_in = S_MIX1;
            end
         end
         S_MIX1: begin
            cmd.mix1 = 1'b1;
            cmd.mul = 1'b1;
            state_in = S_MIX2;
         end
         S_MIX2: begin
            cmd.mix2 = 1'b1;
            cmd.div_init = 1'b1;
            state_in = S_MIX3;
         end
         S_MIX3: begin
            cmd.mix3 = 1'b1;
            cmd.div_step = 1'b1;
            state_in = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) state_in = S_RD;
         end
         S_RD: begin
            cmd.rd = 1'b1;
            state_in = S_RDW;
         end
         S_RDW: state_in = S_WR;
         S_WR: begin
            cmd.wr = sts.is_count;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!vld_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               vld_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
   end

endmodule

// ===== design/hph_datapath.sv =====
module hph_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  hph_pkg::cmd_type         cmd,
   output hph_pkg::sts_type         sts,
   input  logic                     csr_valid,
   input  logic [1:0]               csr_index,
   input  logic [31:0]              csr_data,
   input  logic [1:0]               in_mode,
   input  logic [31:0]              in_key,
   input  logic [10:0]              in_index,
   output logic [10:0]              out_partition,
   output logic [9:0]               out_bin,
   output logic [31:0]              out_count
);
   import hph_pkg::*;

   localparam logic [COUNT_WIDTH-1:0] CMAX = '1;

   logic [3:0]  pbits_ff;
   logic [10:0] nbins_ff;
   logic [31:0] maxk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pbits_ff <= 4'd11;
         nbins_ff <= 11'd1000;
         maxk_ff  <= 32'd500000;
      end else if (csr_valid) begin
         case (csr_index)
            REG_PART_BITS: pbits_ff <= csr_data[3:0];
            REG_BIN_COUNT: nbins_ff <= csr_data[10:0];
            REG_MAX_KEY:   maxk_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   logic [1:0]  mode_ff;
   logic [31:0] key_ff;
   logic [10:0] idx_ff;
   logic [31:0] h_ff;
   logic [PART_W-1:0] part_ff;
   logic [10:0] nb_ff;
   logic [31:0] mk_ff;
   logic [42:0] prod_ff;
   logic [42:0] quo_ff;
   logic [31:0] rem_ff;
   logic [5:0]  dcnt_ff;

   logic [31:0] x1, x2;
   assign x1 = h_ff ^ (h_ff >> 16);
   assign x2 = h_ff ^ (h_ff >> 13);

   logic [31:0] hf;
   logic [3:0]  pb;
   logic [31:0] psh;
   assign hf  = h_ff ^ (h_ff >> 16);
   assign pb  = (pbits_ff > 4'(MAX_PART_BITS)) ? 4'(MAX_PART_BITS) : pbits_ff;
   assign psh = (pb == 4'd0) ? 32'd0 : (hf >> (6'd32 - {2'b00, pb}));

   logic [32:0] trial;
   assign trial = {rem_ff, prod_ff[42 - dcnt_ff]} - {1'b0, mk_ff};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= in_mode;
         key_ff  <= in_key;
         idx_ff  <= in_index;
         h_ff    <= in_key;
         nb_ff   <= (nbins_ff == 11'd0) ? 11'd1 :
                    (nbins_ff > 11'(BIN_SLOTS)) ? 11'(BIN_SLOTS) : nbins_ff;
         mk_ff   <= (maxk_ff == 32'd0) ? 32'd1 : maxk_ff;
      end
      if (cmd.mix1) h_ff <= x1 * MIX_C1;
      if (cmd.mix2) h_ff <= x2 * MIX_C2;
      if (cmd.mix3) part_ff <= psh[PART_W-1:0];
      if (cmd.mul) prod_ff <= key_ff * nb_ff;
      // restoring division, one quotient bit a cycle
      if (cmd.div_init) begin
         rem_ff  <= '0;
         quo_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step && dcnt_ff != 6'd43) begin
         if (!trial[32]) begin
            rem_ff <= trial[31:0];
            quo_ff <= {quo_ff[41:0], 1'b1};
         end else begin
            rem_ff <= {rem_ff[30:0], prod_ff[42 - dcnt_ff]};
            quo_ff <= {quo_ff[41:0], 1'b0};
         end
         dcnt_ff <= dcnt_ff + 6'd1;
      end
   end

   logic [BIN_W-1:0] bin_v;
   assign bin_v = (quo_ff >= {32'd0, nb_ff}) ? BIN_W'(nb_ff - 11'd1) : quo_ff[BIN_W-1:0];

   assign sts.div_done = (dcnt_ff == 6'd43);
   assign sts.is_count = (mode_ff == MODE_COUNT);

   // clearing sweep over both memories
   logic [PART_W:0] clr_ff;
   always_ff @(posedge clock) begin
      if (reset) clr_ff <= '0;
      else if (cmd.clr && !clr_ff[PART_W]) clr_ff <= clr_ff + 1'b1;
   end
   assign sts.clr_done = clr_ff[PART_W];

   logic [COUNT_WIDTH-1:0] bmem [BIN_SLOTS];
   logic [COUNT_WIDTH-1:0] pmem [PARTITIONS];
   logic [COUNT_WIDTH-1:0] brd_ff, prd_ff;
   logic [BIN_W-1:0]  badr;
   logic [PART_W-1:0] padr;
   assign badr = (mode_ff == MODE_COUNT) ? bin_v : idx_ff[BIN_W-1:0];
   assign padr = (mode_ff == MODE_COUNT) ? part_ff : idx_ff[PART_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         brd_ff <= bmem[badr];
         prd_ff <= pmem[padr];
      end
      if (cmd.clr) begin
         bmem[clr_ff[BIN_W-1:0]]  <= '0;
         pmem[clr_ff[PART_W-1:0]] <= '0;
      end else if (cmd.wr) begin
         bmem[badr] <= (brd_ff == CMAX) ? brd_ff : brd_ff + 1'b1;
         pmem[padr] <= (prd_ff == CMAX) ? prd_ff : prd_ff + 1'b1;
      end
   end

   logic [10:0] opart_ff;
   logic [9:0]  obin_ff;
   logic [31:0] ocnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         opart_ff <= (mode_ff == MODE_COUNT) ? 11'(part_ff) : 11'd0;
         obin_ff  <= (mode_ff == MODE_COUNT) ? 10'(bin_v) : 10'd0;
         case (mode_ff)
            MODE_READ_BIN: ocnt_ff <= ({1'b0, idx_ff} < 12'(BIN_SLOTS)) ?
                                      32'(brd_ff) : 32'd0;
            MODE_READ_PRT: ocnt_ff <= ({1'b0, idx_ff} < 12'(PARTITIONS)) ?
                                      32'(prd_ff) : 32'd0;
            default:       ocnt_ff <= 32'd0;
         endcase
      end
   end

   assign out_partition = opart_ff;
   assign out_bin       = obin_ff;
   assign out_count     = ocnt_ff;

endmodule

// ===== design/hash_partition_histogram.sv =====
// An accepted req beat goes through 3 hash steps while a one-bit-per-cycle serial
//   divider forms the bin, then a read and a write-back, before rsp_tvalid rises.
// A new req beat is taken only after the last result has been loaded; a stalled
//   result holds off the next accept until it leaves.
// Reset: synchronous, active high; then a clearing pass zeroes both counter
//   memories while req_tready stays low. Control and CSR registers take reset values.
module hash_partition_histogram (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // key[31:0], index[42:32], zero fill
   input  logic [1:0]  req_tuser,  // mode[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // partition[10:0], bin[20:11], count[52:21], zero fill
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   import hph_pkg::*;

   cmd_type cmd;
   sts_type sts;
   logic [10:0] part;
   logic [9:0]  bin;
   logic [31:0] cnt;

   assign csr_ready = 1'b1;
   assign rsp_tdata = {3'd0, cnt, bin, part};

   hph_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .sts(sts), .cmd(cmd)
   );

   hph_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .csr_valid(csr_valid), .csr_index(csr_index), .csr_data(csr_data),
      .in_mode(req_tuser), .in_key(req_tdata[31:0]), .in_index(req_tdata[42:32]),
      .out_partition(part), .out_bin(bin), .out_count(cnt)
   );

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accept while busy");

   a_clear_first: assert property (@(posedge clock) disable iff (reset)
      !sts.clr_done |-> !req_tready)
      else $error("accept during clear");

   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && rsp_tvalid))
      else $error("result changed while stalled");

endmodule

// ===== tb/sv/tb_hash_partition_histogram.sv =====
module tb_hash_partition_histogram;
   timeunit 1ns;
   timeprecision 1ps;
   import hph_pkg::*;

   typedef struct {
      logic [10:0] partition;
      logic [9:0]  bin;
      logic [31:0] count;
   } hist_result_type;

   class hist_scoreboard;
      logic [31:0]  bin_cnt [BIN_SLOTS];
      logic [31:0]  part_cnt [PARTITIONS];
      logic [3:0]   pbits;
      logic [10:0]  nbins;
      logic [31:0]  mkey;
      hist_result_type pending [$];
      int           errors;

      function new();
         foreach (bin_cnt[i]) bin_cnt[i] = '0;
         foreach (part_cnt[i]) part_cnt[i] = '0;
         pbits = 4'd11;
         nbins = 11'd1000;
         mkey = 32'd500000;
         errors = 0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [31:0] val);
         case (idx)
            REG_PART_BITS: pbits = val[3:0];
            REG_BIN_COUNT: nbins = val[10:0];
            REG_MAX_KEY:   mkey = val;
            default: ;
         endcase
      endfunction

      function logic [31:0] fmix(logic [31:0] h);
         h = h ^ (h >> 16);
         h = h * 32'h85ebca6b;
         h = h ^ (h >> 13);
         h = h * 32'hc2b2ae35;
         h = h ^ (h >> 16);
         return h;
      endfunction

      function void note_item(logic [1:0] mode, logic [31:0] key, logic [10:0] idx);
         hist_result_type r;
         int unsigned pb;
         longint unsigned nb, mk, b, p;
         logic [31:0] h;
         r.partition = '0;
         r.bin = '0;
         r.count = '0;
         if (mode == MODE_COUNT) begin
            h = fmix(key);
            pb = (pbits > MAX_PART_BITS) ? MAX_PART_BITS : pbits;
            p = (pb == 0) ? 0 : (h >> (32 - pb));
            p = p % PARTITIONS;
            nb = (nbins == 0) ? 1 : nbins;
            if (nb > BIN_SLOTS) nb = BIN_SLOTS;
            mk = (mkey == 0) ? 1 : mkey;
            b = (longint'(key) * nb) / mk;
            if (b >= nb) b = nb - 1;
            if (part_cnt[p] != '1) part_cnt[p]++;
            if (bin_cnt[b] != '1) bin_cnt[b]++;
            r.partition = p[10:0];
            r.bin = b[9:0];
         end else if (mode == MODE_READ_BIN) begin
            if (idx < BIN_SLOTS) r.count = bin_cnt[idx];
         end else if (mode == MODE_READ_PRT) begin
            r.count = part_cnt[idx];
         end
         pending.push_back(r);
      endfunction

      function void check_result(logic [55:0] d);
         hist_result_type e;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, d);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (d[10:0] !== e.partition) begin
            $display("%0t: partition expected %0d actual %0d", $time, e.partition, d[10:0]);
            errors++;
         end
         if (d[20:11] !== e.bin) begin
            $display("%0t: bin expected %0d actual %0d", $time, e.bin, d[20:11]);
            errors++;
         end
         if (d[52:21] !== e.count) begin
            $display("%0t: count expected %0d actual %0d", $time, e.count, d[52:21]);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   hist_scoreboard sb = new();
   bit quiet_tail = 0;
   bit hold_rsp = 0;

   hash_partition_histogram dut (.*);

   initial forever #4 clock = ~clock;

   initial begin
      #200ms;
      $display("Some tests failed");
      $finish;
   end

   // leaves req_tvalid high after the beat; the next call or the caller drops it
   task automatic send_item(logic [1:0] mode, logic [31:0] key, logic [10:0] idx);
      if (!quiet_tail && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= mode;
      req_tdata <= {5'd0, idx, key};
      do @(posedge clock); while (!req_tready);
      sb.note_item(mode, key, idx);
      @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      req_tvalid <= 0;
      wait (sb.pending.size() == 0);
      repeat (60) @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(idx, val);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic random_item();
      int unsigned sel;
      logic [31:0] k;
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, 3) == 0 ? $urandom_range(0, 600000) : $urandom();
      if (sel < 70) send_item(MODE_COUNT, k, 11'($urandom()));
      else if (sel < 83) send_item(MODE_READ_BIN, $urandom(), 11'($urandom()));
      else if (sel < 96) send_item(MODE_READ_PRT, $urandom(), 11'($urandom()));
      else send_item(MODE_NONE, $urandom(), 11'($urandom()));
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      @(negedge clock);
      while (1) begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
            rsp_tready <= 0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end else begin
            rsp_tready <= 1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata);

   initial begin
      int n;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: default config
      send_item(MODE_COUNT, 32'd0, 11'd0);
      send_item(MODE_COUNT, 32'hFFFFFFFF, 11'h7FF);
      send_item(MODE_COUNT, 32'd499999, 11'd0);
      send_item(MODE_COUNT, 32'd500000, 11'd0);
      send_item(MODE_READ_BIN, 32'hFFFFFFFF, 11'd999);
      send_item(MODE_READ_BIN, 32'd0, 11'd0);
      send_item(MODE_READ_BIN, 32'd0, 11'd1024);
      send_item(MODE_READ_BIN, 32'd0, 11'h7FF);
      send_item(MODE_READ_PRT, 32'd0, 11'h7FF);
      send_item(MODE_NONE, 32'hFFFFFFFF, 11'h7FF);
      write_reg(REG_PART_BITS, 32'd0);
      write_reg(REG_BIN_COUNT, 32'd0);
      write_reg(REG_MAX_KEY, 32'd0);
      send_item(MODE_COUNT, 32'h12345678, 11'd0);
      send_item(MODE_READ_PRT, 32'd0, 11'd0);
      send_item(MODE_READ_BIN, 32'd0, 11'd0);
      write_reg(REG_PART_BITS, 32'hF);
      write_reg(REG_BIN_COUNT, 32'h7FF);
      write_reg(REG_MAX_KEY, 32'hFFFFFFFF);
      send_item(MODE_COUNT, 32'hFFFFFFFF, 11'd0);
      send_item(MODE_COUNT, 32'h80000000, 11'd0);
      send_item(MODE_READ_BIN, 32'd0, 11'd1023);
      write_reg(REG_PART_BITS, 32'd1);
      write_reg(REG_BIN_COUNT, 32'd1024);
      write_reg(REG_MAX_KEY, 32'd1);
      send_item(MODE_COUNT, 32'd1, 11'd0);
      send_item(MODE_READ_PRT, 32'd0, 11'd1);
      // random phases over several settings
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) begin
            write_reg(REG_PART_BITS, $urandom_range(0, 15));
            write_reg(REG_BIN_COUNT, $urandom_range(0, 2047));
            write_reg(REG_MAX_KEY, $urandom_range(0, 3) == 0 ? $urandom() :
                                   $urandom_range(1, 1000000));
         end
         if (ph == 2) hold_rsp = 1;
         if (ph == 5) quiet_tail = 1;
         n = 220;
         for (int i = 0; i < n; i++) begin
            random_item();
            if (i == 100 && ph == 3) begin
               req_tvalid <= 0;
               wait (sb.pending.size() == 0);
               @(negedge clock);
            end
         end
      end
      req_tvalid <= 0;
      wait (sb.pending.size() == 0);
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end
endmodule
